// ----- src/swm_pkg.sv -----
package swm_pkg;

  // configuration register file
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned WIN_LEN_W     = 6;
  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 6'd5;

  // word index of the window length register (paddr[2])
  localparam logic REG_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic [15:0] sample_distance;
    logic [15:0] sample_angle;
  } in_word_t;

  typedef struct packed {
    logic [15:0]          median_distance;
    logic [15:0]          median_angle;
    logic [WIN_LEN_W-1:0] fill_count;
  } out_word_t;

  // register file to sequencer
  typedef struct packed {
    logic                 restart;
    logic [WIN_LEN_W-1:0] window_len;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_SCAN,
    ST_LEFT,
    ST_RIGHT,
    ST_PLACE,
    ST_FINISH
  } seq_state_t;

endpackage

// ----- src/swm_cfg.sv -----
module swm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::PADDR_W-1:0]   paddr,
  input  logic [swm_pkg::PDATA_W-1:0]   pwdata,
  output logic [swm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output swm_pkg::cfg_t                 cfg
);
  import swm_pkg::*;

  logic [WIN_LEN_W-1:0] window_len;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_LEN_RESET;
    end else if (wr_en) begin
      window_len <= pwdata[WIN_LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_LEN) begin
      prdata = PDATA_W'(window_len);
    end
  end

  // a new length restarts the window at the same edge if the sequencer is idle
  assign cfg.restart    = wr_en;
  assign cfg.window_len = window_len;

endmodule

// ----- src/swm_core.sv -----
module swm_core #(
  parameter int unsigned MAX_WINDOW = 32,
  parameter int unsigned DIST_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swm_pkg::cfg_t        cfg,
  input  logic                 take,
  input  swm_pkg::in_word_t    item,
  output logic                 busy,
  output logic                 res_valid,
  input  logic                 res_take,
  output swm_pkg::out_word_t   res
);
  import swm_pkg::*;

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IW = CW + 1;
  localparam int unsigned EW = DIST_BITS + 16;

  seq_state_t state, state_next;

  logic [EW-1:0] e_q, e_next;
  logic [AW-1:0] wp, wp_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  logic          moved, moved_next;
  logic          fwd, fwd_next;
  logic [CW-1:0] len_eff;

  // arrival ring and sorted copy, one write and one read port each
  logic [EW-1:0] ring_mem [MAX_WINDOW];
  logic [EW-1:0] sort_mem [MAX_WINDOW];
  logic          ring_re, ring_we;
  logic [EW-1:0] ring_rd;
  logic          s_re, s_we;
  logic [AW-1:0] s_ra, s_wa;
  logic [EW-1:0] s_wd, s_rd;

  logic [DIST_BITS-1:0] e_dist, rd_dist;
  logic [31:0]          in_d32, out_d32;
  logic [EW-1:0]        res_entry;

  logic          launch, rlaunch, fin;
  logic [AW-1:0] lp, rp, fp;

  always_comb begin
    if (cfg.window_len == '0) begin
      len_eff = CW'(1);
    end else if (32'(cfg.window_len) > MAX_WINDOW) begin
      len_eff = CW'(MAX_WINDOW);
    end else begin
      len_eff = CW'(cfg.window_len);
    end
  end

  assign in_d32  = 32'(item.sample_distance);
  assign e_dist  = e_q[EW-1:16];
  assign rd_dist = s_rd[EW-1:16];

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp] <= e_q;
    end
    if (ring_re) begin
      ring_rd <= ring_mem[wp];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sort_mem[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_rd <= sort_mem[s_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      count <= '0;
      moved <= 1'b0;
      fwd   <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      count <= count_next;
      moved <= moved_next;
      fwd   <= fwd_next;
    end
    e_q <= e_next;
    pos <= pos_next;
  end

  always_comb begin
    state_next = state;
    e_next     = e_q;
    wp_next    = wp;
    count_next = count;
    pos_next   = pos;
    moved_next = moved;
    fwd_next   = fwd;
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    s_re       = 1'b0;
    s_ra       = '0;
    s_we       = 1'b0;
    s_wa       = '0;
    s_wd       = e_q;
    launch     = 1'b0;
    lp         = '0;
    rlaunch    = 1'b0;
    rp         = '0;
    fin        = 1'b0;
    fp         = '0;

    case (state)
      ST_IDLE: begin
        // a length write restarts the window ahead of a word taken at the same edge
        if (cfg.restart) begin
          wp_next    = '0;
          count_next = '0;
        end
        if (take) begin
          e_next     = {in_d32[DIST_BITS-1:0], item.sample_angle};
          ring_re    = 1'b1;
          state_next = ST_OLD;
        end
      end
      ST_OLD: begin
        ring_we = 1'b1;
        wp_next = (IW'(wp) + IW'(1) >= IW'(len_eff)) ? '0 : wp + AW'(1);
        if (IW'(count) < IW'(len_eff)) begin
          count_next = count + CW'(1);
          launch     = 1'b1;
          lp         = AW'(count);
        end else begin
          s_re       = 1'b1;
          s_ra       = '0;
          pos_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // first exact match of the oldest entry, else the last slot
        if (s_rd == ring_rd || IW'(pos) + IW'(1) == IW'(len_eff)) begin
          launch = 1'b1;
          lp     = pos;
        end else begin
          s_re     = 1'b1;
          s_ra     = pos + AW'(1);
          pos_next = pos + AW'(1);
        end
      end
      ST_LEFT: begin
        if (e_dist < rd_dist) begin
          s_we       = 1'b1;
          s_wa       = pos;
          s_wd       = s_rd;
          moved_next = 1'b1;
          if (pos > AW'(1)) begin
            s_re     = 1'b1;
            s_ra     = pos - AW'(2);
            pos_next = pos - AW'(1);
          end else begin
            fin = 1'b1;
            fp  = pos - AW'(1);
          end
        end else if (moved) begin
          fin = 1'b1;
          fp  = pos;
        end else begin
          rlaunch = 1'b1;
          rp      = pos;
        end
      end
      ST_RIGHT: begin
        if (e_dist > rd_dist) begin
          s_we = 1'b1;
          s_wa = pos;
          s_wd = s_rd;
          if (IW'(pos) + IW'(2) < IW'(count)) begin
            s_re     = 1'b1;
            s_ra     = pos + AW'(2);
            pos_next = pos + AW'(1);
          end else begin
            fin = 1'b1;
            fp  = pos + AW'(1);
          end
        end else begin
          fin = 1'b1;
          fp  = pos;
        end
      end
      ST_PLACE: begin
        // drop the new entry in and fetch the median in the same cycle
        s_we       = 1'b1;
        s_wa       = pos;
        s_wd       = e_q;
        s_re       = 1'b1;
        s_ra       = AW'(count >> 1);
        fwd_next   = (AW'(count >> 1) == pos);
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (launch) begin
      if (lp != '0) begin
        s_re       = 1'b1;
        s_ra       = lp - AW'(1);
        pos_next   = lp;
        moved_next = 1'b0;
        state_next = ST_LEFT;
      end else begin
        rlaunch = 1'b1;
        rp      = lp;
      end
    end
    if (rlaunch) begin
      if (IW'(rp) + IW'(1) < IW'(count_next)) begin
        s_re       = 1'b1;
        s_ra       = rp + AW'(1);
        pos_next   = rp;
        state_next = ST_RIGHT;
      end else begin
        fin = 1'b1;
        fp  = rp;
      end
    end
    if (fin) begin
      pos_next   = fp;
      state_next = ST_PLACE;
    end
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_FINISH);
  assign res_entry = fwd ? e_q : s_rd;
  assign out_d32   = 32'(res_entry[EW-1:16]);

  assign res.median_distance = out_d32[15:0];
  assign res.median_angle    = res_entry[15:0];
  assign res.fill_count      = WIN_LEN_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    IW'(count) <= IW'(len_eff))
    else $error("fill count beyond window length");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    IW'(wp) < IW'(len_eff))
    else $error("ring pointer beyond window length");

  a_move_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEFT || state == ST_RIGHT) |->
      (IW'(pos) < IW'(count) && IW'(pos_next) <= IW'(pos) + IW'(1)))
    else $error("sorted move outside the filled part");

  a_same_addr: assert property (@(posedge clk) disable iff (rst)
    (s_we && s_re && s_wa == s_ra) |-> (state == ST_PLACE) ##1 (fwd && state == ST_FINISH))
    else $error("read and write of one sorted entry without forwarding");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (count != '0 && $stable(count)))
    else $error("result with an empty window");

endmodule

// ----- src/sliding_window_median.sv -----
// sliding window median of range readings
//
// input channel in_valid / in_stall / in_word carries one distance and angle word;
// output channel out_valid / out_stall / out_word returns one median word for each
// input word, with the angle of the median entry and the current fill count.
// a word moves at a rising edge where valid is high and stall is low.
//
// sequence: while the window fills, an item is written to the arrival ring and its new
// entry is shifted into place in the sorted copy. once full, the sorted copy is
// scanned for the oldest entry one entry per cycle and the new entry is then shifted
// one place per cycle. both rates come from the single read port of the sorted
// memory. the median word is read from the sorted memory as the new entry is written
// into place, and in_stall stays high while an item is at work.
//
// a finished median sits in the output register; the next input word is taken while
// it waits, and that item's own result waits in the sequencer until the register frees.
// reset (rst, synchronous) empties the window and sets window_len to 5. writing
// window_len over the apb port also empties the window; write it only while idle.
module sliding_window_median #(
  parameter int unsigned MAX_WINDOW = 32,
  parameter int unsigned DIST_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  swm_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swm_pkg::out_word_t            out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::PADDR_W-1:0]   paddr,
  input  logic [swm_pkg::PDATA_W-1:0]   pwdata,
  output logic [swm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import swm_pkg::*;

  cfg_t      cfg;
  logic      busy;
  logic      take;
  logic      res_valid;
  logic      res_take;
  out_word_t res;

  // register file: window length and restart strobe
  swm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer around the arrival ring and the sorted memory
  swm_core #(
    .MAX_WINDOW (MAX_WINDOW),
    .DIST_BITS  (DIST_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .item      (in_word),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // input side: a word is taken only when the sequencer has nothing in flight
  assign in_stall = busy;
  assign take     = in_valid && !busy;

  // output register parts the sequencer from the receiver
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      out_word <= res;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled output word changed");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy)
    else $error("taken word did not start the sequencer");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    res_take |=> !res_valid)
    else $error("result delivered twice");

endmodule
